### hw/rtl/sst_pkg.sv
`default_nettype none
package sst_pkg;

  localparam int TOL_W = 10;
  localparam int LIM_W = 6;
  localparam int REV_W = 10;
  localparam int CFG_W = 10;

  localparam logic REG_TOLERANCE = 1'b0;
  localparam logic REG_REV_LIMIT = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SETUP,
    S_FETCH,
    S_MUL,
    S_DECIDE,
    S_CROSS,
    S_CWAIT,
    S_DLOAD,
    S_DIV,
    S_RLOAD,
    S_ROOT,
    S_JUDGE,
    S_FINAL
  } state_t;

  typedef enum logic [3:0] {
    MOP_NONE,
    MOP_DXDX,
    MOP_DYDY,
    MOP_PXPX,
    MOP_PYPY,
    MOP_QXQX,
    MOP_QYQY,
    MOP_PXDX,
    MOP_PYDY,
    MOP_DXPY,
    MOP_DYPX,
    MOP_CHH,
    MOP_CHL,
    MOP_CLL
  } mop_t;

  typedef enum logic [1:0] {
    RES_FALSE,
    RES_TRUE,
    RES_REV
  } res_t;

  typedef enum logic [1:0] {
    TREND_NONE,
    TREND_UP,
    TREND_DOWN
  } trend_t;

  typedef struct packed {
    logic load;
    logic setup;
    mop_t mop;
    logic advance;
    logic div_load;
    logic div_step;
    logic root_load;
    logic root_quot;
    logic root_step;
    logic trend;
    logic finish;
    res_t res;
  } cmd_t;

  typedef struct packed {
    logic ovf;
    logic n_lt2;
    logic n_eq2;
    logic perp;
    logic too_far;
    logic more;
  } stat_t;

endpackage
`default_nettype wire

### hw/rtl/sst_ram.sv
`default_nettype none
module sst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

### hw/rtl/sst_ctrl.sv
`default_nettype none
module sst_ctrl
  import sst_pkg::*;
#(
  parameter int DIV_STEPS  = 49,
  parameter int ROOT_STEPS = 25
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire logic  last_point,
  input  wire stat_t stat,
  output cmd_t       cmd,
  output logic       busy
);

  localparam int SW = $clog2(DIV_STEPS + 1);

  state_t        state, state_next;
  logic [SW-1:0] step, step_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.mop    = MOP_NONE;
    cmd.res    = RES_FALSE;
    state_next = state;
    step_next  = step;
    unique case (state)
      S_IDLE: begin
        cmd.load = start;
        if (start && last_point) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (stat.ovf || stat.n_lt2) begin
          cmd.finish = 1'b1;
          cmd.res    = RES_FALSE;
          state_next = S_IDLE;
        end else if (stat.n_eq2) begin
          cmd.finish = 1'b1;
          cmd.res    = RES_TRUE;
          state_next = S_IDLE;
        end else begin
          cmd.setup  = 1'b1;
          step_next  = '0;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.mop = step[0] ? MOP_DYDY : MOP_DXDX;
        if (step[0]) begin
          step_next  = '0;
          state_next = S_FETCH;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_FETCH: begin
        step_next  = '0;
        state_next = S_MUL;
      end
      S_MUL: begin
        unique case (step[2:0])
          3'd0: cmd.mop = MOP_PXPX;
          3'd1: cmd.mop = MOP_PYPY;
          3'd2: cmd.mop = MOP_QXQX;
          3'd3: cmd.mop = MOP_QYQY;
          3'd4: cmd.mop = MOP_PXDX;
          3'd5: cmd.mop = MOP_PYDY;
          3'd6: cmd.mop = MOP_DXPY;
          3'd7: cmd.mop = MOP_DYPX;
          default: cmd.mop = MOP_NONE;
        endcase
        if (step[2:0] == 3'd7) begin
          step_next  = '0;
          state_next = S_DECIDE;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_DECIDE: begin
        step_next = '0;
        if (stat.perp) begin
          state_next = S_CROSS;
        end else begin
          cmd.root_load = 1'b1;
          cmd.root_quot = 1'b0;
          state_next    = S_ROOT;
        end
      end
      S_CROSS: begin
        unique case (step[1:0])
          2'd0: cmd.mop = MOP_CHH;
          2'd1: cmd.mop = MOP_CHL;
          2'd2: cmd.mop = MOP_CLL;
          default: cmd.mop = MOP_NONE;
        endcase
        if (step[1:0] == 2'd2) begin
          step_next  = '0;
          state_next = S_CWAIT;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_CWAIT: begin
        state_next = S_DLOAD;
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        step_next    = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step == SW'(DIV_STEPS - 1)) begin
          step_next  = '0;
          state_next = S_RLOAD;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_RLOAD: begin
        cmd.root_load = 1'b1;
        cmd.root_quot = 1'b1;
        step_next     = '0;
        state_next    = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (step == SW'(ROOT_STEPS - 1)) begin
          step_next  = '0;
          state_next = S_JUDGE;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_JUDGE: begin
        if (stat.too_far) begin
          cmd.finish = 1'b1;
          cmd.res    = RES_FALSE;
          state_next = S_IDLE;
        end else begin
          cmd.trend   = 1'b1;
          cmd.advance = 1'b1;
          state_next  = stat.more ? S_FETCH : S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.finish = 1'b1;
        cmd.res    = RES_REV;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/sst_datapath.sv
`default_nettype none
module sst_datapath
  import sst_pkg::*;
#(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic signed [COORD_BITS-1:0] point_x,
  input  wire logic signed [COORD_BITS-1:0] point_y,
  input  wire logic                         cfg_write,
  input  wire logic                         cfg_index,
  input  wire logic [CFG_W-1:0]             cfg_data,
  input  wire cmd_t                         cmd,
  output stat_t                             stat,
  output logic                              done,
  output logic                              is_line,
  output logic                              overflowed
);

  localparam int AW   = $clog2(MAX_POINTS);
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int CW   = COORD_BITS;
  localparam int DW   = CW + 1;
  localparam int MW   = CW + 2;
  localparam int PW   = 2 * MW;
  localparam int LW   = 2 * CW + 1;
  localparam int CMW  = 2 * CW + 1;
  localparam int HB   = CW + 1;
  localparam int NAW  = 2 * CMW;
  localparam int QW   = 2 * CW + 1 + 2 * FRAC_BITS;
  localparam int RW   = (QW + 1) / 2;
  localparam int XW   = NAW + 2 * FRAC_BITS;
  localparam int EW   = RW + 3;

  logic [TOL_W-1:0] tol;
  logic [LIM_W-1:0] lim;
  logic [CNTW-1:0]  cnt;
  logic             ovf;
  logic [AW-1:0]    last_idx;
  logic signed [CW-1:0] ax, ay, bx, by;
  logic [AW:0]      k;

  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [2*CW-1:0]  ram_rdata;
  logic signed [CW-1:0] pxr, pyr;

  logic signed [DW-1:0] dx, dy, px, py, qx, qy;
  logic signed [MW-1:0] ma, mb;
  logic signed [PW-1:0] prod;
  mop_t             op_d;

  logic [LW-1:0]    len2, s1, s2, smin;
  logic signed [PW-1:0] dot, crs;
  logic [PW-1:0]    crs_abs;
  logic [CMW-1:0]   cmag;
  logic [NAW-1:0]   nacc, prod_n;

  logic [XW-1:0]    xw;
  logic [LW-1:0]    drem;
  logic [QW-1:0]    dlow;
  logic [LW:0]      div_t, div_sub;
  logic             div_ge;

  logic [QW-1:0]    ep_rad;
  logic [2*RW-1:0]  rad;
  logic [RW+1:0]    rrem;
  logic [RW-1:0]    root;
  logic [RW+3:0]    rt_t, rt_trial, rt_diff;
  logic             rt_ge;

  logic [RW-1:0]    prev;
  trend_t           trend;
  logic [REV_W-1:0] rev;
  logic [EW-1:0]    d_e, prev_e, tolf, diff_up, diff_dn, six_up, six_dn;

  assign ram_we   = cmd.load && (cnt < CNTW'(MAX_POINTS));
  assign ram_addr = cmd.load ? cnt[AW-1:0] : k[AW-1:0];

  sst_ram #(
    .WIDTH(2 * CW),
    .DEPTH(MAX_POINTS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata({point_y, point_x}),
    .rdata(ram_rdata)
  );

  assign pxr = ram_rdata[CW-1:0];
  assign pyr = ram_rdata[2*CW-1:CW];

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_W'(16);
      lim <= LIM_W'(5);
    end else if (cfg_write) begin
      if (cfg_index == REG_TOLERANCE) begin
        tol <= cfg_data[TOL_W-1:0];
      end else begin
        lim <= cfg_data[LIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      ovf <= 1'b0;
    end else if (cmd.finish) begin
      cnt <= '0;
      ovf <= 1'b0;
    end else if (cmd.load) begin
      if (ram_we) begin
        cnt <= cnt + 1'b1;
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      last_idx <= cnt[AW-1:0];
      bx       <= point_x;
      by       <= point_y;
      if (cnt == '0) begin
        ax <= point_x;
        ay <= point_y;
      end
    end
  end

  assign dx = DW'(bx) - DW'(ax);
  assign dy = DW'(by) - DW'(ay);
  assign px = DW'(pxr) - DW'(ax);
  assign py = DW'(pyr) - DW'(ay);
  assign qx = DW'(pxr) - DW'(bx);
  assign qy = DW'(pyr) - DW'(by);

  assign crs_abs = crs[PW-1] ? PW'(-crs) : PW'(crs);
  assign cmag    = crs_abs[CMW-1:0];

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.mop)
      MOP_DXDX: begin ma = MW'(dx); mb = MW'(dx); end
      MOP_DYDY: begin ma = MW'(dy); mb = MW'(dy); end
      MOP_PXPX: begin ma = MW'(px); mb = MW'(px); end
      MOP_PYPY: begin ma = MW'(py); mb = MW'(py); end
      MOP_QXQX: begin ma = MW'(qx); mb = MW'(qx); end
      MOP_QYQY: begin ma = MW'(qy); mb = MW'(qy); end
      MOP_PXDX: begin ma = MW'(px); mb = MW'(dx); end
      MOP_PYDY: begin ma = MW'(py); mb = MW'(dy); end
      MOP_DXPY: begin ma = MW'(dx); mb = MW'(py); end
      MOP_DYPX: begin ma = MW'(dy); mb = MW'(px); end
      MOP_CHH: begin ma = MW'(cmag[CMW-1:HB]); mb = MW'(cmag[CMW-1:HB]); end
      MOP_CHL: begin ma = MW'(cmag[CMW-1:HB]); mb = MW'(cmag[HB-1:0]); end
      MOP_CLL: begin ma = MW'(cmag[HB-1:0]); mb = MW'(cmag[HB-1:0]); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_d <= MOP_NONE;
    end else begin
      op_d <= cmd.mop;
    end
    prod <= ma * mb;
  end

  assign prod_n = NAW'($unsigned(prod));

  always_ff @(posedge clk) begin
    unique case (op_d)
      MOP_DXDX: len2 <= prod[LW-1:0];
      MOP_DYDY: len2 <= len2 + prod[LW-1:0];
      MOP_PXPX: s1 <= prod[LW-1:0];
      MOP_PYPY: s1 <= s1 + prod[LW-1:0];
      MOP_QXQX: s2 <= prod[LW-1:0];
      MOP_QYQY: s2 <= s2 + prod[LW-1:0];
      MOP_PXDX: dot <= prod;
      MOP_PYDY: dot <= dot + prod;
      MOP_DXPY: crs <= prod;
      MOP_DYPX: crs <= crs - prod;
      MOP_CHH:  nacc <= prod_n << (2 * HB);
      MOP_CHL:  nacc <= nacc + (prod_n << (HB + 1));
      MOP_CLL:  nacc <= nacc + prod_n;
      default: ;
    endcase
  end

  assign smin = (s1 < s2) ? s1 : s2;

  assign xw      = XW'(nacc) << (2 * FRAC_BITS);
  assign div_t   = {drem, dlow[QW-1]};
  assign div_ge  = div_t >= {1'b0, len2};
  assign div_sub = div_t - {1'b0, len2};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      drem <= xw[XW-1:QW];
      dlow <= xw[QW-1:0];
    end else if (cmd.div_step) begin
      drem <= div_ge ? div_sub[LW-1:0] : div_t[LW-1:0];
      dlow <= {dlow[QW-2:0], div_ge};
    end
  end

  assign ep_rad   = QW'(smin) << (2 * FRAC_BITS);
  assign rt_t     = {rrem, rad[2*RW-1 -: 2]};
  assign rt_trial = (RW + 4)'({root, 2'b01});
  assign rt_ge    = rt_t >= rt_trial;
  assign rt_diff  = rt_t - rt_trial;

  always_ff @(posedge clk) begin
    if (cmd.root_load) begin
      rad  <= cmd.root_quot ? (2 * RW)'(dlow) : (2 * RW)'(ep_rad);
      rrem <= '0;
      root <= '0;
    end else if (cmd.root_step) begin
      rrem <= rt_ge ? rt_diff[RW+1:0] : rt_t[RW+1:0];
      root <= {root[RW-2:0], rt_ge};
      rad  <= rad << 2;
    end
  end

  assign d_e     = EW'(root);
  assign prev_e  = EW'(prev);
  assign tolf    = EW'(tol) << FRAC_BITS;
  assign diff_up = d_e - prev_e;
  assign diff_dn = prev_e - d_e;
  assign six_up  = (diff_up << 2) + (diff_up << 1);
  assign six_dn  = (diff_dn << 2) + (diff_dn << 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev  <= '0;
      trend <= TREND_NONE;
      rev   <= '0;
      k     <= '0;
    end else if (cmd.setup) begin
      prev  <= '0;
      trend <= TREND_NONE;
      rev   <= '0;
      k     <= (AW + 1)'(1);
    end else if (cmd.trend) begin
      k <= k + (AW + 1)'(2);
      if (d_e > prev_e) begin
        if (trend != TREND_UP && six_up >= tolf) begin
          if (rev != '1) begin
            rev <= rev + 1'b1;
          end
          trend <= TREND_UP;
          prev  <= root;
        end
      end else if (d_e < prev_e) begin
        if (trend != TREND_DOWN && six_dn >= tolf) begin
          if (rev != '1) begin
            rev <= rev + 1'b1;
          end
          trend <= TREND_DOWN;
          prev  <= root;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
    if (cmd.finish) begin
      overflowed <= ovf;
      unique case (cmd.res)
        RES_FALSE: is_line <= 1'b0;
        RES_TRUE:  is_line <= 1'b1;
        RES_REV:   is_line <= (rev <= REV_W'(lim));
        default:   is_line <= 1'b0;
      endcase
    end
  end

  assign stat.ovf     = ovf;
  assign stat.n_lt2   = (last_idx == '0);
  assign stat.n_eq2   = (last_idx == AW'(1));
  assign stat.perp    = (len2 != '0) && !dot[PW-1] && ($unsigned(dot) <= PW'(len2));
  assign stat.too_far = d_e > tolf;
  assign stat.more    = ((AW + 2)'(k) + (AW + 2)'(2)) < (AW + 2)'(last_idx);

endmodule
`default_nettype wire

### hw/rtl/stroke_straightness_check.sv
// Channel   Handshake            Payload
// point     start / busy         point_x, point_y, last_point
// config    cfg_write            cfg_index, cfg_data
// verdict   done (one cycle)     is_line, overflowed
//
// A point is taken in one cycle while busy is low. The closing point starts the
// judging walk over the odd inner points: a point that projects outside the chord
// goes straight to the root, one inside goes first through the divider, whose
// Q = 2*COORD_BITS + 1 + 2*FRAC_BITS quotient bits come one quotient bit a cycle,
// then the root, R = (Q + 1) / 2 bits at one bit a cycle. Reset is synchronous;
// the point store is not cleared. The verdict cannot be stalled.
`default_nettype none
module stroke_straightness_check
  import sst_pkg::*;
#(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [COORD_BITS-1:0] point_x,
  input  wire logic signed [COORD_BITS-1:0] point_y,
  input  wire logic                         last_point,
  input  wire logic                         cfg_write,
  input  wire logic                         cfg_index,
  input  wire logic [CFG_W-1:0]             cfg_data,
  output logic                              done,
  output logic                              is_line,
  output logic                              overflowed
);

  localparam int QW = 2 * COORD_BITS + 1 + 2 * FRAC_BITS;
  localparam int RW = (QW + 1) / 2;

  cmd_t  cmd;
  stat_t stat;

  sst_ctrl #(
    .DIV_STEPS (QW),
    .ROOT_STEPS(RW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .last_point(last_point),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  sst_datapath #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .point_x   (point_x),
    .point_y   (point_y),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .done      (done),
    .is_line   (is_line),
    .overflowed(overflowed)
  );

endmodule
`default_nettype wire

### verif/tb_stroke_straightness_check.sv
`timescale 1ns / 100ps
`default_nettype none

class stroke_judge_board;
  int sx[1024];
  int sy[1024];
  int n_pts;
  bit ovf;
  int unsigned tol;
  int unsigned lim;
  bit [1:0] verdict_q[$];
  int mismatches;
  int verdicts;
  int lines;
  int overflows;

  function new();
    tol = 16;
    lim = 5;
  endfunction

  function longint unsigned mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // largest d with d*d*den <= num
  function longint unsigned fx_root(bit [191:0] num, bit [191:0] den);
    longint unsigned d;
    bit [191:0] c;
    d = 0;
    for (int b = 47; b >= 0; b--) begin
      c = d | (64'd1 << b);
      if (c * c * den <= num) d = c;
    end
    return d;
  endfunction

  function longint unsigned chord_dist(int k);
    longint dx, dy, px, py, qx, qy, dot;
    longint unsigned len2, c, s1, s2;
    dx = sx[n_pts-1] - sx[0];
    dy = sy[n_pts-1] - sy[0];
    px = sx[k] - sx[0];
    py = sy[k] - sy[0];
    qx = sx[k] - sx[n_pts-1];
    qy = sy[k] - sy[n_pts-1];
    len2 = mag(dx) * mag(dx) + mag(dy) * mag(dy);
    dot = px * dx + py * dy;
    if (len2 != 0 && dot >= 0 && dot <= len2) begin
      c = mag(dx * py - dy * px);
      return fx_root(192'(c) * 192'(c) << 16, 192'(len2));
    end
    s1 = mag(px) * mag(px) + mag(py) * mag(py);
    s2 = mag(qx) * mag(qx) + mag(qy) * mag(qy);
    return fx_root(192'((s1 < s2) ? s1 : s2) << 16, 192'd1);
  endfunction

  function bit judge_stroke();
    longint unsigned tolf, d, prev;
    logic [1:0] trend;
    int unsigned revs;
    tolf = longint'(tol) << 8;
    prev = 0;
    trend = 2'd0;
    revs = 0;
    if (n_pts < 2) return 0;
    if (n_pts == 2) return 1;
    for (int i = 1; i + 1 < n_pts; i += 2) begin
      d = chord_dist(i);
      if (d > tolf) return 0;
      if (d > prev) begin
        if (trend != 2'd1 && 6 * (d - prev) >= tolf) begin
          if (revs < 1023) revs++;
          trend = 2'd1;
          prev = d;
        end
      end else if (d < prev) begin
        if (trend != 2'd2 && 6 * (prev - d) >= tolf) begin
          if (revs < 1023) revs++;
          trend = 2'd2;
          prev = d;
        end
      end
    end
    return revs <= lim;
  endfunction

  function void note_point(int x, int y, bit last);
    bit line;
    if (n_pts < 1024) begin
      sx[n_pts] = x;
      sy[n_pts] = y;
      n_pts++;
    end else begin
      ovf = 1;
    end
    if (!last) return;
    line = ovf ? 1'b0 : judge_stroke();
    verdict_q.push_back({line, ovf});
    n_pts = 0;
    ovf = 0;
  endfunction

  function void check_verdict(bit line, bit of);
    bit [1:0] exp_v;
    verdicts++;
    lines += line;
    overflows += of;
    if (verdict_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected verdict is_line=%0d overflowed=%0d", line, of);
      return;
    end
    exp_v = verdict_q.pop_front();
    if (exp_v != {line, of}) begin
      mismatches++;
      if (mismatches <= 10)
        $display("verdict %0d: expected is_line=%0d overflowed=%0d, got %0d %0d",
                 verdicts, exp_v[1], exp_v[0], line, of);
    end
  endfunction
endclass

module tb_stroke_straightness_check;
  import sst_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic signed [15:0] point_x = 0;
  logic signed [15:0] point_y = 0;
  logic last_point = 0;
  logic cfg_write = 0;
  logic cfg_index = REG_TOLERANCE;
  logic [CFG_W-1:0] cfg_data = 0;
  logic done;
  logic is_line;
  logic overflowed;

  stroke_judge_board board = new();
  bit gaps_on = 1;
  int items_sent;
  int strokes_sent;

  stroke_straightness_check i_dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && done) board.check_verdict(is_line, overflowed);
  end

  function int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  task send_point(int x, int y, bit last);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    start <= 1;
    point_x <= 16'(x);
    point_y <= 16'(y);
    last_point <= last;
    do @(posedge clk); while (busy);
    board.note_point(x, y, last);
    items_sent++;
  endtask

  task drain();
    start <= 0;
    @(posedge clk);
    while (board.verdict_q.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_reg(logic idx, int unsigned val);
    drain();
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    @(posedge clk);
    cfg_write <= 0;
    if (idx == REG_TOLERANCE) board.tol = val;
    else board.lim = val;
  endtask

  // points along a chord, inner points jittered by up to amp pixels in x and in y
  task send_stroke(int n, int ax, int ay, int bx, int by, int amp);
    int x, y;
    for (int i = 0; i < n; i++) begin
      x = (n > 1) ? ax + (bx - ax) * i / (n - 1) : ax;
      y = (n > 1) ? ay + (by - ay) * i / (n - 1) : ay;
      if (i != 0 && i != n - 1 && amp > 0) begin
        x += $urandom_range(0, 2 * amp) - amp;
        y += $urandom_range(0, 2 * amp) - amp;
      end
      send_point(clamp16(x), clamp16(y), i == n - 1);
    end
    strokes_sent++;
  endtask

  initial begin
    int n, ax, ay, bx, by, amp;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_point(100, 100, 1);
    send_stroke(2, -32768, 32767, 32767, -32768, 0);
    send_stroke(3, 0, 0, 0, 0, 0);
    send_point(10, 10, 0);
    send_point(500, 700, 0);
    send_point(10, 10, 1);
    send_point(0, 0, 0);
    send_point(-3000, 20, 0);
    send_point(100, 0, 0);
    send_point(8000, 5, 0);
    send_point(100, 0, 1);
    send_stroke(5, -32768, -32768, 32767, 32767, 0);
    send_stroke(7, -32768, 0, 32767, 0, 40);
    write_reg(REG_TOLERANCE, 0);
    send_stroke(5, 0, 0, 1000, 0, 0);
    send_stroke(5, 0, 0, 999, 333, 0);
    write_reg(REG_TOLERANCE, 1023);
    write_reg(REG_REV_LIMIT, 0);
    send_stroke(9, -20000, 5000, 20000, -5000, 3000);
    write_reg(REG_REV_LIMIT, 63);
    write_reg(REG_TOLERANCE, 16);
    write_reg(REG_REV_LIMIT, 5);

    while (items_sent < 500) begin
      if (strokes_sent % 20 == 0) begin
        case ($urandom_range(0, 3))
          0: write_reg(REG_TOLERANCE, 0);
          1: write_reg(REG_TOLERANCE, 1023);
          default: write_reg(REG_TOLERANCE, $urandom_range(1, 64));
        endcase
        write_reg(REG_REV_LIMIT, ($urandom_range(0, 2) == 0) ? 63 : $urandom_range(0, 6));
      end
      if (items_sent > 420) gaps_on = 0;
      case ($urandom_range(0, 9))
        0: n = $urandom_range(1, 2);
        1: n = $urandom_range(26, 60);
        default: n = $urandom_range(3, 25);
      endcase
      ax = $urandom_range(0, 65535) - 32768;
      ay = $urandom_range(0, 65535) - 32768;
      bx = $urandom_range(0, 65535) - 32768;
      by = $urandom_range(0, 65535) - 32768;
      if ($urandom_range(0, 9) == 0) begin
        bx = ax;
        by = ay;
      end
      case ($urandom_range(0, 4))
        0: amp = 0;
        1: amp = board.tol / 3 + 1;
        2: amp = board.tol + 1;
        3: amp = 2 * board.tol + 2;
        default: amp = $urandom_range(0, 70000);
      endcase
      send_stroke(n, ax, ay, bx, by, amp);
    end
    drain();
    repeat (100) @(posedge clk);

    $display("%0d points in %0d strokes, %0d verdicts (%0d lines, %0d overflows), %0d mismatches",
             items_sent, strokes_sent, board.verdicts, board.lines, board.overflows,
             board.mismatches);
    if (board.mismatches == 0 && board.verdict_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end
endmodule

`default_nettype wire
